// ===== rtl/ltg_pkg.sv =====
// ----------------------------------------------------------------------------
// ltg_pkg
// Shared types, constants and helpers for the toroidal life grid block.
// ----------------------------------------------------------------------------
package ltg_pkg;

    // field widths of the request and result words
    localparam int FUNC_W = 2;
    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;

    // configuration port
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;
    localparam logic [CFG_W-1:0]     SIZE_RESET = 7'd64;

    // default grid dimensions
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    // life rule thresholds
    localparam int NBR_W = 4;
    localparam logic [NBR_W-1:0] BIRTH_COUNT = 4'd3;
    localparam logic [NBR_W-1:0] STAY_COUNT  = 4'd2;

    // glider preset: rows one to three, columns two to four
    localparam int GLIDER_FIRST_ROW = 1;
    localparam int GLIDER_LAST_ROW  = 3;
    localparam int GLIDER_SPAN      = 8;
    localparam int GLIDER_IDX_W     = $clog2(GLIDER_SPAN);

    // request codes
    typedef enum logic [FUNC_W-1:0] {
        FN_TOGGLE  = 2'd0,
        FN_ADVANCE = 2'd1,
        FN_READ    = 2'd2,
        FN_GLIDER  = 2'd3
    } t_func;

    // width that holds both a size register and the largest size
    function automatic int size_width(input int max_n);
        int w;
        w = $clog2(max_n + 1);
        if (w < CFG_W) begin
            w = CFG_W;
        end
        return w;
    endfunction

    // live columns of the glider preset in a given row
    function automatic logic [GLIDER_SPAN-1:0] glider_cols(input logic [1:0] row);
        logic [GLIDER_SPAN-1:0] m;
        case (row)
            2'd1:    m = 8'b0000_1000;
            2'd2:    m = 8'b0001_0000;
            2'd3:    m = 8'b0001_1100;
            default: m = 8'b0000_0000;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/ltg_ram.sv =====
// ----------------------------------------------------------------------------
// ltg_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ltg_ram
    import ltg_pkg::*;
#(
    parameter int WIDTH = DEF_MAX_COLS,
    parameter int DEPTH = DEF_MAX_ROWS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ltg_row_update.sv =====
// ----------------------------------------------------------------------------
// ltg_row_update
// Applies the life rule to one whole row from the rows above and below,
// with the columns wrapping at the width in use.
// ----------------------------------------------------------------------------
module ltg_row_update
    import ltg_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic [MAX_COLS-1:0]             i_prev,
    input  logic [MAX_COLS-1:0]             i_cur,
    input  logic [MAX_COLS-1:0]             i_next,
    input  logic [size_width(MAX_COLS)-1:0] i_cols,
    output logic [MAX_COLS-1:0]             o_row
);

    localparam int CE_W = size_width(MAX_COLS);
    localparam int CA_W = $clog2(MAX_COLS);

    logic [CA_W-1:0] w_last;
    logic            w_prev_last;
    logic            w_cur_last;
    logic            w_next_last;

    // bits in the last column in use, left neighbours of column zero
    assign w_last      = CA_W'(i_cols - CE_W'(1));
    assign w_prev_last = i_prev[w_last];
    assign w_cur_last  = i_cur[w_last];
    assign w_next_last = i_next[w_last];

    for (genvar j = 0; j < MAX_COLS; j++) begin : g_col
        logic             l_p, l_c, l_n;
        logic             r_p, r_c, r_n;
        logic [NBR_W-1:0] w_cnt;
        logic             w_alive;

        // left neighbours
        if (j == 0) begin : g_left_wrap
            assign l_p = w_prev_last;
            assign l_c = w_cur_last;
            assign l_n = w_next_last;
        end else begin : g_left
            assign l_p = i_prev[j-1];
            assign l_c = i_cur[j-1];
            assign l_n = i_next[j-1];
        end

        // right neighbours, wrapping to column zero past the width in use
        if (j == MAX_COLS - 1) begin : g_right_wrap
            assign r_p = i_prev[0];
            assign r_c = i_cur[0];
            assign r_n = i_next[0];
        end else begin : g_right
            logic w_wrap;
            assign w_wrap = (CE_W'(j + 1) >= i_cols);
            assign r_p = w_wrap ? i_prev[0] : i_prev[j+1];
            assign r_c = w_wrap ? i_cur[0]  : i_cur[j+1];
            assign r_n = w_wrap ? i_next[0] : i_next[j+1];
        end

        // neighbour count and rule
        assign w_cnt = NBR_W'(l_p) + NBR_W'(l_c) + NBR_W'(l_n)
                     + NBR_W'(i_prev[j]) + NBR_W'(i_next[j])
                     + NBR_W'(r_p) + NBR_W'(r_c) + NBR_W'(r_n);
        assign w_alive = (w_cnt == BIRTH_COUNT) || (i_cur[j] && (w_cnt == STAY_COUNT));

        // columns outside the width in use keep their contents
        assign o_row[j] = (CE_W'(j) < i_cols) ? w_alive : i_cur[j];
    end

endmodule

// ===== rtl/life_automaton_torus_grid_unit.sv =====
// ----------------------------------------------------------------------------
// life_automaton_torus_grid_unit
// Toroidal life grid: toggle, read, glider preset and generation step.
// ----------------------------------------------------------------------------
// Usage
//   Request channel i_valid / o_stall carries a word of i_func, i_row and
//   i_col; a word is taken on an edge with i_valid high and o_stall low.
//   Result channel o_valid / i_stall carries o_cell_alive and o_out_of_range,
//   one result word per request, in request order.
//   Sizes in use are written through i_cfg_we / i_cfg_idx / i_cfg_wdata;
//   index 0 sets rows, index 1 sets columns. The user must write them only
//   while the block is idle; the block itself does not enforce this.
// Sequencing
//   One request at a time. A generation step sweeps the grid RAM one row per
//   cycle through the shared row update unit, with a three-row window held
//   in registers.
// Reset
//   Synchronous, active low. Afterwards the grid RAM is cleared one row per
//   cycle, all MAX_ROWS rows, with o_stall high; sizes return to 64.
// Stall
//   A result waits in the output register while i_stall is high; the next
//   request is still taken and its result is held until the register frees.
// ----------------------------------------------------------------------------
module life_automaton_torus_grid_unit
    import ltg_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [FUNC_W-1:0]    i_func,
    input  logic [ROW_W-1:0]     i_row,
    input  logic [COL_W-1:0]     i_col,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_cell_alive,
    output logic                 o_out_of_range,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam int RA_W = $clog2(MAX_ROWS);
    localparam int CA_W = $clog2(MAX_COLS);
    localparam int RE_W = size_width(MAX_ROWS);
    localparam int CE_W = size_width(MAX_COLS);

    typedef enum logic [10:0] {
        S_CLEAR    = 11'b000_0000_0001,
        S_IDLE     = 11'b000_0000_0010,
        S_CELL_RD  = 11'b000_0000_0100,
        S_CELL_USE = 11'b000_0000_1000,
        S_GL_RD    = 11'b000_0001_0000,
        S_GL_WR    = 11'b000_0010_0000,
        S_GEN_P0   = 11'b000_0100_0000,
        S_GEN_P1   = 11'b000_1000_0000,
        S_GEN_P2   = 11'b001_0000_0000,
        S_GEN_RUN  = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic [RA_W-1:0]     r_row, n_row;
    logic [CFG_W-1:0]    r_rows_cfg, r_cols_cfg;
    t_func               r_func;
    logic [ROW_W-1:0]    r_row_in;
    logic [COL_W-1:0]    r_col_in;
    logic                r_inside;
    logic [MAX_COLS-1:0] r_prev, n_prev;
    logic [MAX_COLS-1:0] r_cur, n_cur;
    logic [MAX_COLS-1:0] r_row0, n_row0;
    logic                r_res_alive, n_res_alive;
    logic                r_res_oor, n_res_oor;
    logic                r_out_valid, r_out_alive, r_out_oor;

    logic [RE_W-1:0]        w_nr;
    logic [CE_W-1:0]        w_nc;
    logic                   w_accept;
    logic                   w_in_inside;
    logic                   w_res_load;
    logic                   w_has_next;
    logic [MAX_COLS-1:0]    w_next_row;
    logic [MAX_COLS-1:0]    w_new_row;
    logic [GLIDER_SPAN-1:0] w_gl_bits;
    logic [MAX_COLS-1:0]    w_gl_mask;
    logic [MAX_COLS-1:0]    w_cell_onehot;
    logic [CA_W-1:0]        w_col_idx;
    logic [RA_W-1:0]        w_row_addr;
    logic                   w_ram_we;
    logic [RA_W-1:0]        w_ram_waddr;
    logic [MAX_COLS-1:0]    w_ram_wdata;
    logic [RA_W-1:0]        w_ram_raddr;
    logic [MAX_COLS-1:0]    w_rdata;

    // effective sizes, saturated to one up to the grid size
    always_comb begin
        if (r_rows_cfg == '0) begin
            w_nr = RE_W'(1);
        end else if (RE_W'(r_rows_cfg) > RE_W'(MAX_ROWS)) begin
            w_nr = RE_W'(MAX_ROWS);
        end else begin
            w_nr = RE_W'(r_rows_cfg);
        end
        if (r_cols_cfg == '0) begin
            w_nc = CE_W'(1);
        end else if (CE_W'(r_cols_cfg) > CE_W'(MAX_COLS)) begin
            w_nc = CE_W'(MAX_COLS);
        end else begin
            w_nc = CE_W'(r_cols_cfg);
        end
    end

    // request handshake
    assign o_stall     = (r_state != S_IDLE);
    assign w_accept    = i_valid && (r_state == S_IDLE);
    assign w_in_inside = (RE_W'(i_row) < w_nr) && (CE_W'(i_col) < w_nc);

    // addressed cell
    assign w_col_idx     = CA_W'(r_col_in);
    assign w_row_addr    = RA_W'(r_row_in);
    assign w_cell_onehot = MAX_COLS'(1) << w_col_idx;

    // glider bits for the row under the counter, clipped to the width in use
    always_comb begin
        w_gl_bits = glider_cols(r_row[1:0]);
        for (int j = 0; j < MAX_COLS; j++) begin
            w_gl_mask[j] = (j < GLIDER_SPAN) && w_gl_bits[GLIDER_IDX_W'(j % GLIDER_SPAN)]
                         && (CE_W'(j) < w_nc);
        end
    end

    // row below the one being computed, wrapping to the saved row zero
    assign w_has_next = (RE_W'(r_row) + RE_W'(1)) < w_nr;
    assign w_next_row = w_has_next ? w_rdata : r_row0;

    // shared row update unit
    ltg_row_update #(
        .MAX_COLS (MAX_COLS)
    ) u_row_update (
        .i_prev (r_prev),
        .i_cur  (r_cur),
        .i_next (w_next_row),
        .i_cols (w_nc),
        .o_row  (w_new_row)
    );

    // grid store, one row per word
    ltg_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_rdata)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_row0      = r_row0;
        n_res_alive = r_res_alive;
        n_res_oor   = r_res_oor;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_row;
        w_ram_wdata = w_rdata;
        w_ram_raddr = r_row;

        unique case (r_state)
            S_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_wdata = '0;
                n_row       = r_row + RA_W'(1);
                if (r_row == RA_W'(MAX_ROWS - 1)) begin
                    n_row   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    unique case (t_func'(i_func))
                        FN_ADVANCE: begin
                            n_state = S_GEN_P0;
                        end
                        FN_GLIDER: begin
                            n_row   = RA_W'(GLIDER_FIRST_ROW);
                            n_state = S_GL_RD;
                        end
                        FN_TOGGLE, FN_READ: begin
                            if (w_in_inside) begin
                                n_state = S_CELL_RD;
                            end else begin
                                n_res_alive = 1'b0;
                                n_res_oor   = 1'b1;
                                n_state     = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CELL_RD: begin
                w_ram_raddr = w_row_addr;
                n_state     = S_CELL_USE;
            end
            S_CELL_USE: begin
                // toggle writes the row back with the one cell flipped
                w_ram_waddr = w_row_addr;
                w_ram_wdata = w_rdata ^ w_cell_onehot;
                w_ram_we    = (r_func == FN_TOGGLE);
                n_res_alive = w_rdata[w_col_idx] ^ (r_func == FN_TOGGLE);
                n_res_oor   = 1'b0;
                n_state     = S_DONE;
            end
            S_GL_RD: begin
                w_ram_raddr = r_row;
                if (RE_W'(r_row) < w_nr) begin
                    n_state = S_GL_WR;
                end else if (r_inside) begin
                    n_state = S_CELL_RD;
                end else begin
                    n_res_alive = 1'b0;
                    n_res_oor   = 1'b0;
                    n_state     = S_DONE;
                end
            end
            S_GL_WR: begin
                // preset only sets cells alive
                w_ram_we    = 1'b1;
                w_ram_wdata = w_rdata | w_gl_mask;
                n_row       = r_row + RA_W'(1);
                if (r_row != RA_W'(GLIDER_LAST_ROW)) begin
                    n_state = S_GL_RD;
                end else if (r_inside) begin
                    n_state = S_CELL_RD;
                end else begin
                    n_res_alive = 1'b0;
                    n_res_oor   = 1'b0;
                    n_state     = S_DONE;
                end
            end
            S_GEN_P0: begin
                // fetch the last row in use, the upper neighbour of row zero
                w_ram_raddr = RA_W'(w_nr - RE_W'(1));
                n_state     = S_GEN_P1;
            end
            S_GEN_P1: begin
                w_ram_raddr = '0;
                n_prev      = w_rdata;
                n_state     = S_GEN_P2;
            end
            S_GEN_P2: begin
                w_ram_raddr = RA_W'(1);
                n_cur       = w_rdata;
                n_row0      = w_rdata;
                n_row       = '0;
                n_state     = S_GEN_RUN;
            end
            S_GEN_RUN: begin
                // write the new row, slide the window, prefetch two ahead
                w_ram_we    = 1'b1;
                w_ram_waddr = r_row;
                w_ram_wdata = w_new_row;
                w_ram_raddr = RA_W'(r_row + RA_W'(2));
                n_prev      = r_cur;
                n_cur       = w_next_row;
                n_row       = r_row + RA_W'(1);
                if (!w_has_next) begin
                    n_row = '0;
                    if (r_inside) begin
                        n_state = S_CELL_RD;
                    end else begin
                        n_res_alive = 1'b0;
                        n_res_oor   = 1'b0;
                        n_state     = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (w_res_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // result register is free or being emptied
    assign w_res_load = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            if (w_res_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= SIZE_RESET;
            r_cols_cfg <= SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROWS: r_rows_cfg <= i_cfg_wdata;
                REG_COLS: r_cols_cfg <= i_cfg_wdata;
                default:  r_rows_cfg <= r_rows_cfg;
            endcase
        end
    end

    // request word and working rows
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func   <= t_func'(i_func);
            r_row_in <= i_row;
            r_col_in <= i_col;
            r_inside <= w_in_inside;
        end
        r_prev      <= n_prev;
        r_cur       <= n_cur;
        r_row0      <= n_row0;
        r_res_alive <= n_res_alive;
        r_res_oor   <= n_res_oor;
        if (w_res_load) begin
            r_out_alive <= r_res_alive;
            r_out_oor   <= r_res_oor;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_cell_alive   = r_out_alive;
    assign o_out_of_range = r_out_oor;

endmodule

// ===== rtl/ltg_checker.sv =====
// ----------------------------------------------------------------------------
// ltg_checker
// Port-level checks for the toroidal life grid block, bound to the top level.
// ----------------------------------------------------------------------------
module ltg_checker
    import ltg_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_cell_alive,
    input logic o_out_of_range
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cell_alive) && $stable(o_out_of_range))
        else $error("result word changed while stalled");

    // an out of range address never reports a live cell
    a_oor_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_range |-> !o_cell_alive)
        else $error("out of range result with live cell");

    // the grid clear after reset keeps requests out
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("request channel open right after reset");

    // one request at a time: a taken request raises o_stall
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second request taken back to back");

endmodule

bind life_automaton_torus_grid_unit ltg_checker u_ltg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_cell_alive   (o_cell_alive),
    .o_out_of_range (o_out_of_range)
);
